/* rtl/ffba_pkg.sv */
// ---------------------------------------------------------------------------
// ffba_pkg
// Types and codes shared by the first-fit block allocator and its checker.
// ---------------------------------------------------------------------------
`default_nettype none
package ffba_pkg;

   localparam logic [1:0] ACT_ALLOC  = 2'd0;
   localparam logic [1:0] ACT_FREE   = 2'd1;
   localparam logic [1:0] ACT_RESIZE = 2'd2;
   localparam logic [1:0] ACT_ZALLOC = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NULL    = 2'd1;
   localparam logic [1:0] ST_OOM     = 2'd2;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;

   localparam logic       REG_HEAP_START = 1'b0;
   localparam logic       REG_HEAP_END   = 1'b1;

   localparam logic [31:0] MAX_ROUNDABLE = 32'hFFFF_FFF8;

   typedef struct packed {
      logic [31:0] base;
      logic [31:0] size;
      logic        free;
   } entry_type;

endpackage
`default_nettype wire

/* rtl/first_fit_block_allocator_core.sv */
// ---------------------------------------------------------------------------
// first_fit_block_allocator_core
// First-fit heap block allocator; block table held in one synchronous RAM.
// ---------------------------------------------------------------------------
// channel   ports                               handshake
// request   req_action/byte_count/...           start && !busy
// result    rsp_status/result_address/...       rsp_valid, one cycle, no stall
// config    psel/penable/pwrite/paddr/pwdata    psel && penable && pwrite
//
// A request walks the table entry by entry: a free lookup
// scans up to the block count, an allocation up to the block count for
// the first-fit search, and a resize that moves does both (one RAM read
// port). Zeroed allocate adds the S_MUL state, which checks the multiply.
// Synchronous reset empties the table; no clearing pass is needed.
// The result cannot be stalled; a new request is taken while it is shown.
// ---------------------------------------------------------------------------
`default_nettype none
module first_fit_block_allocator_core #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_action,
   input  wire logic [31:0] req_byte_count,
   input  wire logic [31:0] req_element_count,
   input  wire logic [31:0] req_payload_address,
   output logic             rsp_valid,
   output logic [1:0]       rsp_status,
   output logic [31:0]      rsp_result_address,
   output logic [31:0]      rsp_copy_source,
   output logic [31:0]      rsp_copy_length,
   output logic [31:0]      rsp_fill_length,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import ffba_pkg::*;

   localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [31:0] HDR = 32'(HEADER_BYTES);
   localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);

   typedef enum logic [2:0] {
      S_IDLE, S_MUL, S_PREP, S_SCAN, S_APPEND, S_FREE_OLD
   } state_type;

   entry_type mem [MAX_BLOCKS];
   entry_type rdata_ff;
   logic [IW-1:0] raddr;

   state_type state_ff;
   logic [31:0] heap_start_ff, heap_end_ff, brk_ff;
   logic [CW-1:0] count_ff;
   logic [1:0]  act_ff;
   logic [31:0] bytes_ff, addr_ff, size_ff, aligned_ff, res_ff;
   logic [63:0] prod_ff;
   logic        fit_mode_ff;
   logic [CW-1:0] rd_ff, chk_idx_ff;
   logic        chkv_ff;
   logic [IW-1:0] fnd_idx_ff;
   logic [31:0] fnd_base_ff, fnd_size_ff;
   logic        wr_en_ff;
   logic [IW-1:0] wr_addr_ff;
   entry_type   wr_data_ff;
   logic        rsp_valid_ff;
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_result_ff, rsp_csrc_ff, rsp_clen_ff, rsp_flen_ff;

   logic        cfg_wr;
   logic [31:0] pay;
   logic        chk_last;
   logic [33:0] new_break;
   logic [31:0] flen;

   assign cfg_wr    = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (paddr[2] == REG_HEAP_END) ? heap_end_ff : heap_start_ff;
   assign raddr     = rd_ff[IW-1:0];
   assign pay       = rdata_ff.base + HDR;
   assign chk_last  = (CW'(chk_idx_ff + 1'b1) == count_ff);
   assign new_break = {2'b00, brk_ff} + {2'b00, HDR} + {2'b00, aligned_ff};
   assign flen      = (act_ff == ACT_ZALLOC) ? size_ff : 32'd0;

   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
      if (wr_en_ff) begin
         mem[wr_addr_ff] <= wr_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         heap_start_ff <= 32'd0;
         heap_end_ff   <= 32'hFFFF_FFFF;
         brk_ff        <= 32'd0;
         count_ff      <= '0;
         wr_en_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         chkv_ff       <= 1'b0;
      end else begin
         wr_en_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         if (cfg_wr) begin
            if (paddr[2] == REG_HEAP_START) begin
               heap_start_ff <= pwdata;
               if (count_ff == '0) begin
                  brk_ff <= pwdata;
               end
            end else begin
               heap_end_ff <= pwdata;
            end
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  act_ff   <= req_action;
                  bytes_ff <= req_byte_count;
                  addr_ff  <= req_payload_address;
                  size_ff  <= req_byte_count;
                  prod_ff  <= {32'd0, req_element_count} * {32'd0, req_byte_count};
                  rsp_status_ff <= ST_OK;
                  rsp_result_ff <= 32'd0;
                  rsp_csrc_ff   <= 32'd0;
                  rsp_clen_ff   <= 32'd0;
                  rsp_flen_ff   <= 32'd0;
                  rd_ff   <= '0;
                  chkv_ff <= 1'b0;
                  fit_mode_ff <= 1'b0;
                  case (req_action)
                     ACT_ALLOC: state_ff <= S_PREP;
                     ACT_ZALLOC: state_ff <= S_MUL;
                     default: begin
                        if (req_payload_address == 32'd0) begin
                           if (req_action == ACT_FREE) begin
                              rsp_valid_ff <= 1'b1;
                           end else begin
                              state_ff <= S_PREP;
                           end
                        end else if (count_ff == '0) begin
                           rsp_status_ff <= ST_UNKNOWN;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           state_ff <= S_SCAN;
                        end
                     end
                  endcase
               end
            end
            S_MUL: begin
               if (prod_ff[63:32] != 32'd0) begin
                  rsp_status_ff <= ST_OOM;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  size_ff  <= prod_ff[31:0];
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               aligned_ff  <= (size_ff + 32'd7) & ~32'd7;
               rd_ff       <= '0;
               chkv_ff     <= 1'b0;
               fit_mode_ff <= 1'b1;
               if (size_ff == 32'd0) begin
                  rsp_status_ff <= ST_NULL;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end else if (size_ff > MAX_ROUNDABLE) begin
                  rsp_status_ff <= ST_OOM;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end else if (count_ff == '0) begin
                  state_ff <= S_APPEND;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               rd_ff      <= CW'(rd_ff + 1'b1);
               chkv_ff    <= (rd_ff < count_ff);
               chk_idx_ff <= rd_ff;
               if (chkv_ff) begin
                  if (fit_mode_ff) begin
                     if (rdata_ff.free && (rdata_ff.size >= aligned_ff)) begin
                        wr_en_ff   <= 1'b1;
                        wr_addr_ff <= chk_idx_ff[IW-1:0];
                        wr_data_ff <= '{base: rdata_ff.base, size: rdata_ff.size,
                                        free: 1'b0};
                        res_ff     <= pay;
                        if (act_ff == ACT_RESIZE && addr_ff != 32'd0) begin
                           state_ff <= S_FREE_OLD;
                        end else begin
                           rsp_result_ff <= pay;
                           rsp_flen_ff   <= flen;
                           rsp_valid_ff  <= 1'b1;
                           state_ff      <= S_IDLE;
                        end
                     end else if (chk_last) begin
                        state_ff <= S_APPEND;
                     end
                  end else begin
                     if (pay == addr_ff) begin
                        fnd_idx_ff  <= chk_idx_ff[IW-1:0];
                        fnd_base_ff <= rdata_ff.base;
                        fnd_size_ff <= rdata_ff.size;
                        state_ff    <= S_IDLE;
                        if (act_ff == ACT_FREE || bytes_ff == 32'd0) begin
                           wr_en_ff   <= 1'b1;
                           wr_addr_ff <= chk_idx_ff[IW-1:0];
                           wr_data_ff <= '{base: rdata_ff.base, size: rdata_ff.size,
                                           free: 1'b1};
                           rsp_status_ff <= (act_ff == ACT_FREE) ? ST_OK : ST_NULL;
                           rsp_valid_ff  <= 1'b1;
                        end else if (rdata_ff.free) begin
                           rsp_status_ff <= ST_UNKNOWN;
                           rsp_valid_ff  <= 1'b1;
                        end else if (rdata_ff.size >= bytes_ff) begin
                           rsp_result_ff <= addr_ff;
                           rsp_valid_ff  <= 1'b1;
                        end else begin
                           state_ff <= S_PREP;
                        end
                     end else if (chk_last) begin
                        rsp_status_ff <= ST_UNKNOWN;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= S_IDLE;
                     end
                  end
               end
            end
            S_APPEND: begin
               if (count_ff >= MAXC || new_break > {2'b00, heap_end_ff}) begin
                  rsp_status_ff <= ST_OOM;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= S_IDLE;
               end else begin
                  wr_en_ff   <= 1'b1;
                  wr_addr_ff <= count_ff[IW-1:0];
                  wr_data_ff <= '{base: brk_ff, size: aligned_ff, free: 1'b0};
                  count_ff   <= CW'(count_ff + 1'b1);
                  brk_ff     <= new_break[31:0];
                  res_ff     <= brk_ff + HDR;
                  if (act_ff == ACT_RESIZE && addr_ff != 32'd0) begin
                     state_ff <= S_FREE_OLD;
                  end else begin
                     rsp_result_ff <= brk_ff + HDR;
                     rsp_flen_ff   <= flen;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= S_IDLE;
                  end
               end
            end
            S_FREE_OLD: begin
               wr_en_ff      <= 1'b1;
               wr_addr_ff    <= fnd_idx_ff;
               wr_data_ff    <= '{base: fnd_base_ff, size: fnd_size_ff, free: 1'b1};
               rsp_result_ff <= res_ff;
               rsp_csrc_ff   <= addr_ff;
               rsp_clen_ff   <= fnd_size_ff;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_result_ff;
   assign rsp_copy_source    = rsp_csrc_ff;
   assign rsp_copy_length    = rsp_clen_ff;
   assign rsp_fill_length    = rsp_flen_ff;

endmodule
`default_nettype wire

/* rtl/ffba_checker.sv */
// ---------------------------------------------------------------------------
// ffba_checker
// Port-level checks on the allocator's request and result channels.
// ---------------------------------------------------------------------------
`default_nettype none
module ffba_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic [1:0]  rsp_status,
   input wire logic [31:0] rsp_result_address,
   input wire logic [31:0] rsp_copy_length,
   input wire logic [31:0] rsp_fill_length
);
   import ffba_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy || rsp_valid)
      else $error("accepted transfer left block idle without result");

   // a second strobe straight after needs a transfer accepted in between
   a_single_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !(start && !busy) |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_fail_null: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_address == 32'd0)
      else $error("failed request returned an address");

   a_copy_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_copy_length != 32'd0 |->
         rsp_status == ST_OK && rsp_fill_length == 32'd0)
      else $error("copy command on a failed or zeroed transfer");

endmodule

bind first_fit_block_allocator_core ffba_checker u_ffba_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .rsp_valid          (rsp_valid),
   .rsp_status         (rsp_status),
   .rsp_result_address (rsp_result_address),
   .rsp_copy_length    (rsp_copy_length),
   .rsp_fill_length    (rsp_fill_length)
);
`default_nettype wire
